>>> hw/rtl/ppq_pkg.sv
package ppq_pkg;

    // Image geometry.
    localparam int ROW_LENGTH = 2048;
    localparam int ROW_COUNT  = 2048;
    localparam int POS_W      = 11;

    // Sample and power widths.
    localparam int SAMPLE_W = 16;
    localparam int PWR_W    = 32;
    localparam int PIXEL_W  = 8;

    // Ceiling scale register, Q24.
    localparam int                 SCALE_W     = 25;
    localparam int                 SCALE_SHIFT = 24;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 25'd8389;

    localparam logic [PIXEL_W-1:0] GRAY_MAX = 8'd255;

    // Shift-add multiplier: one multiplier bit per cycle.
    localparam int MUL_A_W = PWR_W;
    localparam int MUL_B_W = SCALE_W;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // The scaled difference (p - floor) * 255 carries eight more bits than the power.
    localparam int DIV_N_W = PWR_W + PIXEL_W;

    // Stream payload layout.
    localparam int S_TDATA_W = 2 * SAMPLE_W;
    localparam int S_TUSER_W = 2;
    localparam int M_FIELD_W = PIXEL_W + 2 * POS_W + 2 * PWR_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ_RE,
        ST_SQ_IM,
        ST_CEIL,
        ST_QCMP,
        ST_DIV,
        ST_DONE
    } ppq_state_t;

    // Command from the sequencer to the divider.
    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] numer;
        logic [PWR_W-1:0]   denom;
    } ppq_div_cmd_t;

endpackage

>>> hw/rtl/ppq_mul.sv
module ppq_mul (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [ppq_pkg::MUL_A_W-1:0]  op_a,
    input  logic [ppq_pkg::MUL_B_W-1:0]  op_b,
    output logic                         done,
    output logic [ppq_pkg::MUL_P_W-1:0]  prod
);
    import ppq_pkg::*;

    localparam int CNT_W = $clog2(MUL_B_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MUL_B_W - 1);

    logic [MUL_P_W-1:0] acc_reg, acc_next;
    logic [MUL_A_W-1:0] a_reg, a_next;
    logic [MUL_B_W-1:0] b_reg, b_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               run_reg, run_next;
    logic               done_reg, done_next;
    logic [MUL_A_W:0]   sum;

    // Each cycle adds the multiplicand for the low multiplier bit into the top
    // of the accumulator and shifts the whole accumulator right by one.
    always_comb begin
        sum = {1'b0, acc_reg[MUL_P_W-1:MUL_B_W]} + (b_reg[0] ? {1'b0, a_reg} : '0);
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start) begin
            acc_next = '0;
            a_next   = op_a;
            b_next   = op_b;
            cnt_next = '0;
            run_next = 1'b1;
        end else if (run_reg) begin
            acc_next = {sum, acc_reg[MUL_B_W-1:1]};
            b_next   = b_reg >> 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        cnt_reg <= cnt_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

>>> hw/rtl/ppq_div.sv
module ppq_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ppq_pkg::ppq_div_cmd_t         cmd,
    output logic                          done,
    output logic [ppq_pkg::PIXEL_W-1:0]   quot
);
    import ppq_pkg::*;

    localparam int CNT_W = $clog2(PIXEL_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PIXEL_W - 1);

    // The numerator is n * 255 with n no larger than the divisor, so its upper
    // part is already below the divisor and only eight quotient bits remain.
    logic [PWR_W-1:0]   rem_reg, rem_next;
    logic [PWR_W-1:0]   den_reg, den_next;
    logic [PIXEL_W-1:0] low_reg, low_next;
    logic [PIXEL_W-1:0] q_reg, q_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               run_reg, run_next;
    logic               done_reg, done_next;
    logic [PWR_W:0]     trial;
    logic [PWR_W:0]     diff;
    logic               fits;

    always_comb begin
        trial = {rem_reg, low_reg[PIXEL_W-1]};
        diff  = trial - {1'b0, den_reg};
        fits  = (trial >= {1'b0, den_reg});
        rem_next  = rem_reg;
        den_next  = den_reg;
        low_next  = low_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (cmd.start) begin
            rem_next = cmd.numer[DIV_N_W-1:PIXEL_W];
            low_next = cmd.numer[PIXEL_W-1:0];
            den_next = cmd.denom;
            q_next   = '0;
            cnt_next = '0;
            run_next = 1'b1;
        end else if (run_reg) begin
            rem_next = fits ? diff[PWR_W-1:0] : trial[PWR_W-1:0];
            low_next = low_reg << 1;
            q_next   = {q_reg[PIXEL_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        low_reg <= low_next;
        q_reg   <= q_next;
        cnt_reg <= cnt_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

>>> hw/rtl/power_peak_and_quantize_core.sv
// Power peak detector and 8-bit quantizer for complex image samples.
// Input stream s_*: s_tdata holds sample_re (bits 15:0) and sample_im (31:16),
// s_tuser holds func (bit 0, 0 = measure, 1 = quantize) and frame_start (bit 1).
// Samples arrive in row-major order; internal counters track row and column.
// Result stream m_*: one transfer per input transfer carrying the pixel, the
// position of the first peak and the running peak and floor powers.
// cfg_wen/cfg_wdata write the Q24 ceiling scale; write it only while idle.
// One sample is processed at a time. The power is built by a shift-add
// multiplier that retires one multiplier bit per cycle, first squaring the
// real part and then the imaginary part. A quantize sample adds a compare
// state and, when it falls inside the clip range, a radix-2 divider. The
// first sample of a quantize pass also runs the ceiling multiply.
// A new sample is taken while a finished result waits on m_tready; a stalled
// receiver holds the block only once the next result is ready as well.
// Reset clears the statistics, counters and ceiling, and sets the scale to
// its default of about 0.0005.
module power_peak_and_quantize_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wen,
    input  logic [ppq_pkg::SCALE_W-1:0]    cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // sample_re, sample_im
    input  logic [ppq_pkg::S_TDATA_W-1:0]  s_tdata,
    // func, frame_start
    input  logic [ppq_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // pixel, peak_row, peak_col, peak_value, floor_value, zero fill
    output logic [ppq_pkg::M_TDATA_W-1:0]  m_tdata
);
    import ppq_pkg::*;

    ppq_state_t state_reg, state_next;

    logic [SCALE_W-1:0]  scale_reg;
    logic [PWR_W-1:0]    peak_reg, peak_next;
    logic [PWR_W-1:0]    floor_reg, floor_next;
    logic [PWR_W-1:0]    ceil_reg;
    logic [POS_W-1:0]    prow_reg, prow_next;
    logic [POS_W-1:0]    pcol_reg, pcol_next;
    logic [POS_W-1:0]    row_reg, col_reg;
    logic [POS_W-1:0]    cur_row_reg, cur_col_reg;
    logic                func_reg, start_reg;
    logic [SAMPLE_W-1:0] im_abs_reg;
    logic [PWR_W-1:0]    re2_reg;
    logic [PWR_W-1:0]    power_reg;
    logic [PIXEL_W-1:0]  pix_reg, pix_next;
    logic [PIXEL_W-1:0]  m_pixel_reg;
    logic                m_tvalid_reg;

    logic                accept;
    logic                out_free;
    logic                out_load;
    logic [SAMPLE_W-1:0] re_abs, im_abs;
    logic                in_func, in_start;
    logic [POS_W-1:0]    pos_row, pos_col;
    logic [POS_W:0]      col_inc, row_inc;

    logic                mul_start;
    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic                mul_done;
    logic [MUL_P_W-1:0]  mul_prod;

    ppq_div_cmd_t        div_cmd;
    logic                div_done;
    logic [PIXEL_W-1:0]  div_quot;

    logic                below, above, span_zero;
    logic [PWR_W-1:0]    p_diff, span;
    logic [DIV_N_W-1:0]  numer;

    assign in_func  = s_tuser[0];
    assign in_start = s_tuser[1];
    assign re_abs = s_tdata[SAMPLE_W-1] ? (~s_tdata[SAMPLE_W-1:0] + 1'b1)
                                        : s_tdata[SAMPLE_W-1:0];
    assign im_abs = s_tdata[S_TDATA_W-1] ? (~s_tdata[S_TDATA_W-1:SAMPLE_W] + 1'b1)
                                         : s_tdata[S_TDATA_W-1:SAMPLE_W];

    assign out_free = !m_tvalid_reg || m_tready;

    // Position of the current sample and of the one after it.
    assign pos_row = in_start ? '0 : row_reg;
    assign pos_col = in_start ? '0 : col_reg;
    assign col_inc = {1'b0, pos_col} + 1'b1;
    assign row_inc = {1'b0, pos_row} + 1'b1;

    // Quantize decisions on the registered power.
    assign below     = (power_reg < floor_reg);
    assign above     = (power_reg > ceil_reg);
    assign span      = ceil_reg - floor_reg;
    assign span_zero = (span == '0);
    assign p_diff    = power_reg - floor_reg;
    assign numer     = {p_diff, {PIXEL_W{1'b0}}} - {{PIXEL_W{1'b0}}, p_diff};

    ppq_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    ppq_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (div_cmd),
        .done    (div_done),
        .quot    (div_quot)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_SQ_RE;
                end
            end
            ST_SQ_RE: begin
                if (mul_done) begin
                    state_next = ST_SQ_IM;
                end
            end
            ST_SQ_IM: begin
                if (mul_done) begin
                    if (!func_reg) begin
                        state_next = ST_DONE;
                    end else if (start_reg) begin
                        state_next = ST_CEIL;
                    end else begin
                        state_next = ST_QCMP;
                    end
                end
            end
            ST_CEIL: begin
                if (mul_done) begin
                    state_next = ST_QCMP;
                end
            end
            ST_QCMP: begin
                if (below || above || span_zero) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        s_tready      = 1'b0;
        accept        = 1'b0;
        out_load      = 1'b0;
        mul_start     = 1'b0;
        mul_a         = '0;
        mul_b         = '0;
        div_cmd.start = 1'b0;
        div_cmd.numer = numer;
        div_cmd.denom = span;
        pix_next      = pix_reg;
        case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                accept    = s_tvalid;
                mul_start = s_tvalid;
                mul_a     = MUL_A_W'(re_abs);
                mul_b     = MUL_B_W'(re_abs);
            end
            ST_SQ_RE: begin
                mul_start = mul_done;
                mul_a     = MUL_A_W'(im_abs_reg);
                mul_b     = MUL_B_W'(im_abs_reg);
            end
            ST_SQ_IM: begin
                mul_start = mul_done && func_reg && start_reg;
                mul_a     = peak_reg;
                mul_b     = scale_reg;
            end
            ST_QCMP: begin
                if (below || span_zero) begin
                    pix_next = '0;
                end else if (above) begin
                    pix_next = GRAY_MAX;
                end else begin
                    div_cmd.start = 1'b1;
                end
                if (below) begin
                    pix_next = '0;
                end else if (above) begin
                    pix_next = GRAY_MAX;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    pix_next = div_quot;
                end
            end
            ST_DONE: begin
                out_load = out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Statistics as they stand after the current sample.
    always_comb begin
        peak_next  = peak_reg;
        floor_next = floor_reg;
        prow_next  = prow_reg;
        pcol_next  = pcol_reg;
        if (!func_reg) begin
            if (start_reg) begin
                peak_next  = power_reg;
                floor_next = power_reg;
                prow_next  = '0;
                pcol_next  = '0;
            end else begin
                if (power_reg > peak_reg) begin
                    peak_next = power_reg;
                    prow_next = cur_row_reg;
                    pcol_next = cur_col_reg;
                end
                if (power_reg < floor_reg) begin
                    floor_next = power_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            scale_reg    <= SCALE_RESET;
            peak_reg     <= '0;
            floor_reg    <= '0;
            ceil_reg     <= '0;
            prow_reg     <= '0;
            pcol_reg     <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wen) begin
                scale_reg <= cfg_wdata;
            end
            if (accept) begin
                if (col_inc >= (POS_W+1)'(ROW_LENGTH)) begin
                    col_reg <= '0;
                    row_reg <= (row_inc >= (POS_W+1)'(ROW_COUNT)) ? '0 : row_inc[POS_W-1:0];
                end else begin
                    col_reg <= col_inc[POS_W-1:0];
                    row_reg <= pos_row;
                end
            end
            // Ceiling is the Q24 product shifted down, saturated to 32 bits.
            if (state_reg == ST_CEIL && mul_done) begin
                ceil_reg <= mul_prod[MUL_P_W-1] ? {PWR_W{1'b1}}
                                                : mul_prod[SCALE_SHIFT +: PWR_W];
            end
            if (out_load) begin
                peak_reg  <= peak_next;
                floor_reg <= floor_next;
                prow_reg  <= prow_next;
                pcol_reg  <= pcol_next;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pix_reg <= pix_next;
        if (accept) begin
            func_reg    <= in_func;
            start_reg   <= in_start;
            im_abs_reg  <= im_abs;
            cur_row_reg <= pos_row;
            cur_col_reg <= pos_col;
        end
        if (state_reg == ST_SQ_RE && mul_done) begin
            re2_reg <= mul_prod[PWR_W-1:0];
        end
        if (state_reg == ST_SQ_IM && mul_done) begin
            power_reg <= re2_reg + mul_prod[PWR_W-1:0];
        end
        if (out_load) begin
            m_pixel_reg <= func_reg ? pix_reg : '0;
        end
    end

    // Statistics registers only change when a result is loaded, so they can
    // feed the output directly.
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - M_FIELD_W){1'b0}},
                       floor_reg, peak_reg, pcol_reg, prow_reg, m_pixel_reg};

endmodule

>>> dv/ppq_result_checker.sv
module ppq_result_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wen,
    input  logic [ppq_pkg::SCALE_W-1:0]   cfg_wdata,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    // sample_re, sample_im
    input  logic [ppq_pkg::S_TDATA_W-1:0] s_tdata,
    // func, frame_start
    input  logic [ppq_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    // pixel, peak_row, peak_col, peak_value, floor_value, zero fill
    input  logic [ppq_pkg::M_TDATA_W-1:0] m_tdata,
    output int                            fail_count,
    output int                            results_due
);
    timeunit 1ns;
    timeprecision 1ps;

    import ppq_pkg::*;

    localparam int ROW_LSB   = PIXEL_W;
    localparam int COL_LSB   = ROW_LSB + POS_W;
    localparam int PEAK_LSB  = COL_LSB + POS_W;
    localparam int FLOOR_LSB = PEAK_LSB + PWR_W;

    typedef struct {
        logic [PIXEL_W-1:0] pixel;
        logic [POS_W-1:0]   peak_row;
        logic [POS_W-1:0]   peak_col;
        logic [PWR_W-1:0]   peak_value;
        logic [PWR_W-1:0]   floor_value;
    } gray_result_t;

    gray_result_t gray_results_due[$];

    logic [SCALE_W-1:0] scale;
    logic [PWR_W-1:0]   peak_pwr;
    logic [PWR_W-1:0]   floor_pwr;
    logic [PWR_W-1:0]   ceil_pwr;
    logic [POS_W-1:0]   peak_row;
    logic [POS_W-1:0]   peak_col;
    logic [POS_W-1:0]   row_pos;
    logic [POS_W-1:0]   col_pos;
    int                 mismatches = 0;

    // Advances the image statistics by one sample and returns the gray level
    // transfer that the sample should produce.
    function automatic gray_result_t map_sample(input logic quant, input logic first,
                                                input logic signed [SAMPLE_W-1:0] re,
                                                input logic signed [SAMPLE_W-1:0] im);
        gray_result_t r;
        longint       sq;
        logic [PWR_W-1:0] p;
        logic [63:0]  prod;
        logic [63:0]  span;
        logic [63:0]  q;
        sq = longint'(re) * longint'(re) + longint'(im) * longint'(im);
        p = sq[PWR_W-1:0];
        r.pixel = '0;
        if (first) begin
            row_pos = '0;
            col_pos = '0;
        end
        if (!quant) begin
            if (first) begin
                peak_pwr  = p;
                floor_pwr = p;
                peak_row  = '0;
                peak_col  = '0;
            end else begin
                if (p > peak_pwr) begin
                    peak_pwr = p;
                    peak_row = row_pos;
                    peak_col = col_pos;
                end
                if (p < floor_pwr)
                    floor_pwr = p;
            end
        end else begin
            if (first) begin
                prod = (64'(peak_pwr) * 64'(scale)) >> SCALE_SHIFT;
                ceil_pwr = (prod > 64'hFFFF_FFFF) ? '1 : prod[PWR_W-1:0];
            end
            if (p < floor_pwr) begin
                r.pixel = '0;
            end else if (p > ceil_pwr) begin
                r.pixel = GRAY_MAX;
            end else begin
                span = 64'(ceil_pwr) - 64'(floor_pwr);
                if (span == 0) begin
                    r.pixel = '0;
                end else begin
                    q = (64'(p - floor_pwr) * 64'(GRAY_MAX)) / span;
                    r.pixel = (q > 64'(GRAY_MAX)) ? GRAY_MAX : q[PIXEL_W-1:0];
                end
            end
        end
        if (int'(col_pos) + 1 >= ROW_LENGTH) begin
            col_pos = '0;
            row_pos = (int'(row_pos) + 1 >= ROW_COUNT) ? '0 : row_pos + 1'b1;
        end else begin
            col_pos = col_pos + 1'b1;
        end
        r.peak_row    = peak_row;
        r.peak_col    = peak_col;
        r.peak_value  = peak_pwr;
        r.floor_value = floor_pwr;
        return r;
    endfunction

    function automatic void note_failure(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", msg);
    endfunction

    function automatic void check_field(input string name, input logic [PWR_W-1:0] want,
                                        input logic [PWR_W-1:0] got);
        if (got !== want)
            note_failure($sformatf("mismatch in %s: expected %0d, got %0d", name, want, got));
    endfunction

    always @(posedge aclk) begin
        gray_result_t want;
        gray_result_t got;
        if (!aresetn) begin
            scale     = SCALE_RESET;
            peak_pwr  = '0;
            floor_pwr = '0;
            ceil_pwr  = '0;
            peak_row  = '0;
            peak_col  = '0;
            row_pos   = '0;
            col_pos   = '0;
            gray_results_due.delete();
        end else begin
            if (cfg_wen)
                scale = cfg_wdata;
            if (m_tvalid && m_tready) begin
                got.pixel       = m_tdata[0 +: PIXEL_W];
                got.peak_row    = m_tdata[ROW_LSB +: POS_W];
                got.peak_col    = m_tdata[COL_LSB +: POS_W];
                got.peak_value  = m_tdata[PEAK_LSB +: PWR_W];
                got.floor_value = m_tdata[FLOOR_LSB +: PWR_W];
                if (gray_results_due.size() == 0) begin
                    note_failure($sformatf("result transfer with none outstanding: %h",
                                           m_tdata));
                end else begin
                    want = gray_results_due.pop_front();
                    check_field("pixel", PWR_W'(want.pixel), PWR_W'(got.pixel));
                    check_field("peak_row", PWR_W'(want.peak_row), PWR_W'(got.peak_row));
                    check_field("peak_col", PWR_W'(want.peak_col), PWR_W'(got.peak_col));
                    check_field("peak_value", want.peak_value, got.peak_value);
                    check_field("floor_value", want.floor_value, got.floor_value);
                end
            end
            if (s_tvalid && s_tready)
                gray_results_due.push_back(map_sample(s_tuser[0], s_tuser[1],
                                                      s_tdata[0 +: SAMPLE_W],
                                                      s_tdata[SAMPLE_W +: SAMPLE_W]));
        end
        fail_count  <= mismatches;
        results_due <= gray_results_due.size();
    end

endmodule

>>> dv/tb_power_peak_and_quantize_core.sv
module tb_power_peak_and_quantize_core;
    timeunit 1ns;
    timeprecision 1ps;

    import ppq_pkg::*;

    localparam int               ITEMS         = 1150;
    localparam int               CYCLE_LIMIT   = 1_500_000;
    localparam int               SETTLE_CYCLES = 150;
    localparam logic             FUNC_MEASURE  = 1'b0;
    localparam logic             FUNC_QUANTIZE = 1'b1;
    localparam logic [SCALE_W-1:0] SCALE_MIN   = 25'd1;
    localparam logic [SCALE_W-1:0] SCALE_ONE   = 25'(1 << SCALE_SHIFT);

    typedef enum int {
        MAG_FULL,
        MAG_SMALL,
        MAG_TINY,
        MAG_EDGE
    } magnitude_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wen   = 1'b0;
    logic [SCALE_W-1:0]   cfg_wdata = SCALE_RESET;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [S_TUSER_W-1:0] s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 steady    = 1'b0;
    int                   fail_count;
    int                   results_due;
    int                   samples_sent = 0;
    int                   cycles = 0;

    power_peak_and_quantize_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    ppq_result_checker result_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wen     (cfg_wen),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .results_due (results_due)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 28);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [SAMPLE_W-1:0] pick_part(input magnitude_t mag);
        logic [SAMPLE_W-1:0] v;
        case (mag)
            MAG_FULL:  v = SAMPLE_W'($urandom());
            MAG_SMALL: v = SAMPLE_W'($urandom_range(0, 512) - 256);
            MAG_TINY:  v = SAMPLE_W'($urandom_range(0, 4) - 2);
            default: begin
                case ($urandom_range(0, 4))
                    0:       v = 16'h8000;
                    1:       v = 16'h7FFF;
                    2:       v = 16'h0000;
                    3:       v = 16'hFFFF;
                    default: v = 16'h0001;
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic logic [SCALE_W-1:0] pick_scale();
        logic [SCALE_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = SCALE_MIN;
            1, 2:    v = SCALE_ONE;
            3:       v = SCALE_RESET;
            4:       v = SCALE_W'($urandom_range(1, 1 << SCALE_SHIFT));
            default: v = SCALE_W'($urandom_range(1 << (SCALE_SHIFT - 2), 1 << SCALE_SHIFT));
        endcase
        return v;
    endfunction

    task automatic send_sample(input logic func, input logic first,
                               input logic [SAMPLE_W-1:0] re, input logic [SAMPLE_W-1:0] im);
        if (!steady && $urandom_range(0, 99) < 28) begin
            s_tvalid <= 1'b0;
            // Mostly short gaps; a few long ones land in the middle of the multiply.
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 100)) @(posedge aclk);
            else
                repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {im, re};
        s_tuser  <= {first, func};
        do @(posedge aclk); while (!s_tready);
        samples_sent++;
    endtask

    task automatic send_frame(input logic func, input int len, input magnitude_t mag);
        for (int i = 0; i < len; i++)
            send_sample(func, i == 0, pick_part(mag), pick_part(mag));
    endtask

    // Holds the sender off until every result has come back, then lets the
    // block finish any internal work.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_scale(input logic [SCALE_W-1:0] value);
        settle();
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
    endtask

    initial begin
        int         phase;
        int         len;
        magnitude_t mag;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Before any frame start the floor stays at zero.
        send_sample(FUNC_MEASURE, 1'b0, 16'd100, 16'd0);
        send_sample(FUNC_MEASURE, 1'b0, 16'd0, 16'd300);
        // The ceiling is still zero, so only a zero power avoids the top clip.
        send_sample(FUNC_QUANTIZE, 1'b0, 16'd5, 16'd5);
        send_sample(FUNC_QUANTIZE, 1'b0, 16'd0, 16'd0);
        send_sample(FUNC_MEASURE, 1'b1, 16'h8000, 16'h8000);
        send_sample(FUNC_MEASURE, 1'b0, 16'd0, 16'd0);
        send_sample(FUNC_MEASURE, 1'b0, 16'h7FFF, 16'h7FFF);
        send_sample(FUNC_MEASURE, 1'b0, 16'hFFFF, 16'd1);
        send_sample(FUNC_QUANTIZE, 1'b1, 16'd0, 16'd0);
        send_sample(FUNC_QUANTIZE, 1'b0, 16'h8000, 16'h8000);
        send_sample(FUNC_QUANTIZE, 1'b0, 16'd100, 16'd100);
        send_sample(FUNC_QUANTIZE, 1'b0, 16'd1000, 16'd0);
        // Full scale puts the ceiling on the peak itself.
        write_scale(SCALE_ONE);
        send_sample(FUNC_QUANTIZE, 1'b1, 16'd0, 16'd0);
        send_sample(FUNC_QUANTIZE, 1'b0, 16'h8000, 16'd0);
        send_sample(FUNC_QUANTIZE, 1'b0, 16'h8000, 16'h8000);
        send_sample(FUNC_QUANTIZE, 1'b0, 16'd23170, 16'd23170);
        // A zero span, then a ceiling that falls below the floor.
        write_scale(SCALE_MIN);
        send_sample(FUNC_MEASURE, 1'b1, 16'd0, 16'd0);
        send_sample(FUNC_QUANTIZE, 1'b1, 16'd0, 16'd0);
        send_sample(FUNC_QUANTIZE, 1'b0, 16'd3, 16'd0);
        send_sample(FUNC_MEASURE, 1'b1, 16'd200, 16'd0);
        send_sample(FUNC_MEASURE, 1'b0, 16'd100, 16'd0);
        send_sample(FUNC_QUANTIZE, 1'b1, 16'd0, 16'd0);
        send_sample(FUNC_QUANTIZE, 1'b0, 16'd150, 16'h8000);

        phase = 0;
        while (samples_sent < ITEMS) begin
            steady <= (phase >= 12 && phase < 18);
            if ($urandom_range(0, 3) == 0)
                write_scale(pick_scale());
            else if (phase % 9 == 4)
                settle();
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 250)
                                               : $urandom_range(1, 30);
            mag = magnitude_t'($urandom_range(0, 3));
            case ($urandom_range(0, 9))
                0: begin
                    // Unordered traffic: mixed passes and stray frame starts.
                    repeat (len)
                        send_sample(1'($urandom_range(0, 1)), $urandom_range(0, 9) == 0,
                                    pick_part(mag), pick_part(mag));
                end
                1: begin
                    // A quantize pass that never restarts keeps the old ceiling.
                    send_frame(FUNC_MEASURE, len, mag);
                    repeat ($urandom_range(1, 20))
                        send_sample(FUNC_QUANTIZE, 1'b0, pick_part(mag), pick_part(mag));
                end
                default: begin
                    send_frame(FUNC_MEASURE, len, mag);
                    send_frame(FUNC_QUANTIZE, $urandom_range(1, 40), mag);
                end
            endcase
            phase++;
        end

        settle();
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
